@@ rtl/swot_pkg.sv @@
package swot_pkg;

    localparam int NODE_W     = 6;
    localparam int AMOUNT_W   = 32;
    localparam int OWNER_W    = 6;
    localparam int VALUE_W    = 32;
    localparam int NCOUNT_W   = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [NCOUNT_W-1:0]  NODE_COUNT_RESET = 7'd64;
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_STAKE  = 2'd1;

    typedef enum logic [1:0] {
        OP_LOAD     = 2'd0,
        OP_TRANSFER = 2'd1,
        OP_LOOKUP   = 2'd2,
        OP_READ     = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_COIN  = 2'd1,
        ST_SHORT = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        ADDR_ZERO,
        ADDR_CNT,
        ADDR_CNT_NEXT,
        ADDR_NODE,
        ADDR_PEER
    } t_addr_sel;

    typedef enum logic [1:0] {
        WD_ZERO,
        WD_LOAD,
        WD_SENDER,
        WD_PEER
    } t_wd_sel;

    typedef enum logic [2:0] {
        RES_ZERO,
        RES_LOAD,
        RES_RDATA,
        RES_SHORT,
        RES_COIN,
        RES_TX,
        RES_LK
    } t_res_sel;

    typedef struct packed {
        logic      capture;
        logic      mem_we;
        logic      mem_re;
        t_addr_sel addr_sel;
        t_wd_sel   wd_sel;
        logic      cnt_clr;
        logic      cnt_inc;
        logic      sum_clr;
        logic      sum_acc;
        logic      res_load;
        t_res_sel  res_sel;
        logic      out_load;
    } t_dp_cmd;

    typedef struct packed {
        t_op  op;
        logic node_ok;
        logic peer_ok;
        logic coin_over;
        logic short_stake;
        logic lk_hit;
        logic cnt_last_lk;
        logic cnt_last_clr;
        logic out_free;
    } t_dp_sts;

endpackage

@@ rtl/swot_ram.sv @@
module swot_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/swot_ctrl.sv @@
module swot_ctrl
    import swot_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_dp_sts i_sts,
    output logic    o_in_stall,
    output t_dp_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_RD_WAIT,
        S_TX_SND,
        S_TX_RDP,
        S_TX_PEER,
        S_LK_RUN,
        S_FINISH
    } t_state;

    t_state  r_state;
    t_state  n_state;
    logic    r_in_stall;
    t_dp_cmd cmd;

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                cmd.mem_we   = 1'b1;
                cmd.addr_sel = ADDR_CNT;
                cmd.wd_sel   = WD_ZERO;
                cmd.cnt_inc  = 1'b1;
                if (i_sts.cnt_last_clr) begin
                    cmd.cnt_inc = 1'b0;
                    cmd.cnt_clr = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid && !r_in_stall) begin
                    cmd.capture = 1'b1;
                    n_state     = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_sts.op)
                    OP_LOAD: begin
                        cmd.res_load = 1'b1;
                        cmd.res_sel  = RES_ZERO;
                        if (i_sts.node_ok) begin
                            cmd.mem_we   = 1'b1;
                            cmd.addr_sel = ADDR_NODE;
                            cmd.wd_sel   = WD_LOAD;
                            cmd.res_sel  = RES_LOAD;
                        end
                        n_state = S_FINISH;
                    end
                    OP_READ: begin
                        if (i_sts.node_ok) begin
                            cmd.mem_re   = 1'b1;
                            cmd.addr_sel = ADDR_NODE;
                            n_state      = S_RD_WAIT;
                        end else begin
                            cmd.res_load = 1'b1;
                            cmd.res_sel  = RES_ZERO;
                            n_state      = S_FINISH;
                        end
                    end
                    OP_TRANSFER: begin
                        if (i_sts.node_ok && i_sts.peer_ok) begin
                            cmd.mem_re   = 1'b1;
                            cmd.addr_sel = ADDR_NODE;
                            n_state      = S_TX_SND;
                        end else begin
                            cmd.res_load = 1'b1;
                            cmd.res_sel  = RES_ZERO;
                            n_state      = S_FINISH;
                        end
                    end
                    OP_LOOKUP: begin
                        if (i_sts.coin_over) begin
                            cmd.res_load = 1'b1;
                            cmd.res_sel  = RES_COIN;
                            n_state      = S_FINISH;
                        end else begin
                            cmd.mem_re   = 1'b1;
                            cmd.addr_sel = ADDR_ZERO;
                            cmd.cnt_clr  = 1'b1;
                            cmd.sum_clr  = 1'b1;
                            n_state      = S_LK_RUN;
                        end
                    end
                endcase
            end
            S_RD_WAIT: begin
                cmd.res_load = 1'b1;
                cmd.res_sel  = RES_RDATA;
                n_state      = S_FINISH;
            end
            S_TX_SND: begin
                if (i_sts.short_stake) begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_SHORT;
                    n_state      = S_FINISH;
                end else begin
                    cmd.mem_we   = 1'b1;
                    cmd.addr_sel = ADDR_NODE;
                    cmd.wd_sel   = WD_SENDER;
                    n_state      = S_TX_RDP;
                end
            end
            S_TX_RDP: begin
                cmd.mem_re   = 1'b1;
                cmd.addr_sel = ADDR_PEER;
                n_state      = S_TX_PEER;
            end
            S_TX_PEER: begin
                cmd.mem_we   = 1'b1;
                cmd.addr_sel = ADDR_PEER;
                cmd.wd_sel   = WD_PEER;
                cmd.res_load = 1'b1;
                cmd.res_sel  = RES_TX;
                n_state      = S_FINISH;
            end
            S_LK_RUN: begin
                if (i_sts.lk_hit || i_sts.cnt_last_lk) begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_LK;
                    n_state      = S_FINISH;
                end else begin
                    cmd.mem_re   = 1'b1;
                    cmd.addr_sel = ADDR_CNT_NEXT;
                    cmd.cnt_inc  = 1'b1;
                    cmd.sum_acc  = 1'b1;
                end
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_in_stall <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_in_stall <= (n_state != S_IDLE);
        end
    end

    assign o_in_stall = r_in_stall;
    assign o_cmd      = cmd;

endmodule

@@ rtl/swot_datapath.sv @@
module swot_datapath
    import swot_pkg::*;
#(
    parameter int MAX_NODES  = 64,
    parameter int STAKE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    input  logic [1:0]            i_op,
    input  logic [NODE_W-1:0]     i_node,
    input  logic [NODE_W-1:0]     i_peer,
    input  logic [AMOUNT_W-1:0]   i_amount,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [OWNER_W-1:0]    o_owner,
    output logic [VALUE_W-1:0]    o_stake_value,
    output logic [1:0]            o_status
);

    localparam int IDX_W = $clog2(MAX_NODES);
    localparam int LIM_W = $clog2(MAX_NODES + 1);
    localparam int CW    = (LIM_W > NCOUNT_W) ? LIM_W : NCOUNT_W;
    localparam int SUM_W = STAKE_BITS + NCOUNT_W;
    localparam int CMP_W = (SUM_W > AMOUNT_W) ? SUM_W : AMOUNT_W;
    localparam int VW    = (STAKE_BITS > VALUE_W) ? STAKE_BITS : VALUE_W;
    localparam int PW    = STAKE_BITS + 1;

    localparam logic [STAKE_BITS-1:0] STAKE_MAX = '1;
    localparam logic [VALUE_W-1:0]    VALUE_MAX = '1;

    function automatic logic [VALUE_W-1:0] clip_value(input logic [STAKE_BITS-1:0] v);
        if (VW'(v) > VW'(VALUE_MAX)) begin
            return VALUE_MAX;
        end
        return VALUE_W'(v);
    endfunction

    t_op                   r_op;
    logic [NODE_W-1:0]     r_node;
    logic [NODE_W-1:0]     r_peer;
    logic [AMOUNT_W-1:0]   r_amount;
    logic [NCOUNT_W-1:0]   r_node_count;
    logic [AMOUNT_W-1:0]   r_total_stake;
    logic [IDX_W-1:0]      r_cnt;
    logic [SUM_W-1:0]      r_sum;
    logic [STAKE_BITS-1:0] r_snew;
    logic [OWNER_W-1:0]    r_res_owner;
    logic [VALUE_W-1:0]    r_res_value;
    t_status               r_res_status;
    logic                  r_out_valid;
    logic [OWNER_W-1:0]    r_out_owner;
    logic [VALUE_W-1:0]    r_out_value;
    t_status               r_out_status;

    logic [OWNER_W-1:0]    n_res_owner;
    logic [VALUE_W-1:0]    n_res_value;
    t_status               n_res_status;

    logic [IDX_W-1:0]      addr;
    logic [STAKE_BITS-1:0] wdata;
    logic [STAKE_BITS-1:0] rdata;
    logic [CW-1:0]         n_eff;
    logic [IDX_W-1:0]      last_idx;
    logic [SUM_W-1:0]      sum_next;
    logic [STAKE_BITS-1:0] load_val;
    logic [STAKE_BITS-1:0] snd_new;
    logic [PW-1:0]         peer_sum;
    logic [STAKE_BITS-1:0] peer_sat;
    logic [STAKE_BITS-1:0] tx_val;
    logic                  out_free;

    swot_ram #(
        .WIDTH (STAKE_BITS),
        .DEPTH (MAX_NODES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.mem_we),
        .i_waddr (addr),
        .i_wdata (wdata),
        .i_re    (i_cmd.mem_re),
        .i_raddr (addr),
        .o_rdata (rdata)
    );

    always_comb begin
        if (r_node_count == '0) begin
            n_eff = CW'(1);
        end else if (CW'(r_node_count) > CW'(MAX_NODES)) begin
            n_eff = CW'(MAX_NODES);
        end else begin
            n_eff = CW'(r_node_count);
        end
    end

    assign last_idx = IDX_W'(n_eff - CW'(1));
    assign sum_next = r_sum + SUM_W'(rdata);
    assign load_val = (VW'(r_amount) > VW'(STAKE_MAX)) ? STAKE_MAX : STAKE_BITS'(r_amount);
    assign snd_new  = rdata - STAKE_BITS'(r_amount);
    assign peer_sum = PW'(rdata) + PW'(r_amount);
    assign peer_sat = peer_sum[STAKE_BITS] ? STAKE_MAX : peer_sum[STAKE_BITS-1:0];
    assign tx_val   = (r_peer == r_node) ? peer_sat : r_snew;
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        unique case (i_cmd.addr_sel)
            ADDR_ZERO:     addr = '0;
            ADDR_CNT:      addr = r_cnt;
            ADDR_CNT_NEXT: addr = IDX_W'(r_cnt + IDX_W'(1));
            ADDR_NODE:     addr = IDX_W'(r_node);
            ADDR_PEER:     addr = IDX_W'(r_peer);
            default:       addr = '0;
        endcase
    end

    always_comb begin
        unique case (i_cmd.wd_sel)
            WD_ZERO:   wdata = '0;
            WD_LOAD:   wdata = load_val;
            WD_SENDER: wdata = snd_new;
            WD_PEER:   wdata = peer_sat;
        endcase
    end

    always_comb begin
        o_sts.op           = r_op;
        o_sts.node_ok      = CW'(r_node) < CW'(MAX_NODES);
        o_sts.peer_ok      = CW'(r_peer) < CW'(MAX_NODES);
        o_sts.coin_over    = r_amount > r_total_stake;
        o_sts.short_stake  = VW'(r_amount) > VW'(rdata);
        o_sts.lk_hit       = CMP_W'(r_amount) <= CMP_W'(sum_next);
        o_sts.cnt_last_lk  = r_cnt == last_idx;
        o_sts.cnt_last_clr = r_cnt == IDX_W'(MAX_NODES - 1);
        o_sts.out_free     = out_free;
    end

    always_comb begin
        n_res_owner  = '0;
        n_res_value  = '0;
        n_res_status = ST_OK;
        unique case (i_cmd.res_sel)
            RES_ZERO: begin
            end
            RES_LOAD: begin
                n_res_value = clip_value(load_val);
            end
            RES_RDATA: begin
                n_res_value = clip_value(rdata);
            end
            RES_SHORT: begin
                n_res_value  = clip_value(rdata);
                n_res_status = ST_SHORT;
            end
            RES_COIN: begin
                n_res_status = ST_COIN;
            end
            RES_TX: begin
                n_res_value = clip_value(tx_val);
            end
            RES_LK: begin
                n_res_owner = OWNER_W'(r_cnt);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op     <= t_op'(i_op);
            r_node   <= i_node;
            r_peer   <= i_peer;
            r_amount <= i_amount;
        end
        if (i_cmd.sum_clr) begin
            r_sum <= '0;
        end else if (i_cmd.sum_acc) begin
            r_sum <= sum_next;
        end
        if (i_cmd.mem_we && (i_cmd.wd_sel == WD_SENDER)) begin
            r_snew <= snd_new;
        end
        if (i_cmd.res_load) begin
            r_res_owner  <= n_res_owner;
            r_res_value  <= n_res_value;
            r_res_status <= n_res_status;
        end
        if (i_cmd.out_load) begin
            r_out_owner  <= r_res_owner;
            r_out_value  <= r_res_value;
            r_out_status <= r_res_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt         <= '0;
            r_out_valid   <= 1'b0;
            r_node_count  <= NODE_COUNT_RESET;
            r_total_stake <= '0;
        end else begin
            if (i_cmd.cnt_clr) begin
                r_cnt <= '0;
            end else if (i_cmd.cnt_inc) begin
                r_cnt <= IDX_W'(r_cnt + IDX_W'(1));
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_NODE_COUNT) begin
                    r_node_count <= i_cfg_data[NCOUNT_W-1:0];
                end else if (i_cfg_index == CFG_TOTAL_STAKE) begin
                    r_total_stake <= i_cfg_data[AMOUNT_W-1:0];
                end
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_owner       = r_out_owner;
    assign o_stake_value = r_out_value;
    assign o_status      = r_out_status;

endmodule

@@ rtl/stake_weighted_owner_table.sv @@
// Stake table with weighted owner lookup over the cumulative stake sum.
// Input channel (i_in_valid, o_in_stall) carries one operation per transfer:
// load entry, transfer stake, owner lookup or read entry. Every operation gives
// exactly one result on the output channel (o_out_valid, i_out_stall).
// The configuration channel (i_cfg_valid, o_cfg_ready) is always ready and sets
// the active node count and the total stake; write it only while idle.
// One operation is in flight at a time. A read fetches its table entry before
// its result is registered; a completed transfer reads and updates the sender
// entry, then the peer entry. Owner lookup reads one table entry per cycle from
// the table RAM and walks at most MAX_NODES entries. The input channel accepts
// the next operation in the cycle after its predecessor's result is loaded into
// the output register.
// A new operation is accepted while the previous result still waits.
// After reset a clearing pass zeroes the table, one entry per cycle;
// o_in_stall stays high during it and o_out_valid is low.
// When the receiver stalls, the result is held and the block completes the
// next operation only up to its result, waiting for the output register.
module stake_weighted_owner_table
    import swot_pkg::*;
#(
    parameter int MAX_NODES  = 64,
    parameter int STAKE_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [1:0]            i_op,
    input  logic [NODE_W-1:0]     i_node,
    input  logic [NODE_W-1:0]     i_peer,
    input  logic [AMOUNT_W-1:0]   i_amount,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [OWNER_W-1:0]    o_owner,
    output logic [VALUE_W-1:0]    o_stake_value,
    output logic [1:0]            o_status,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    assign o_cfg_ready = 1'b1;

    swot_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    swot_datapath #(
        .MAX_NODES  (MAX_NODES),
        .STAKE_BITS (STAKE_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_op          (i_op),
        .i_node        (i_node),
        .i_peer        (i_peer),
        .i_amount      (i_amount),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_owner       (o_owner),
        .o_stake_value (o_stake_value),
        .o_status      (o_status)
    );

endmodule

@@ rtl/swot_checker.sv @@
module swot_checker
    import swot_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input logic [OWNER_W-1:0]   o_owner,
    input logic [VALUE_W-1:0]   o_stake_value,
    input logic [1:0]           o_status
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_owner)
            && $stable(o_stake_value) && $stable(o_status))
        else $error("Stalled result changed or was dropped.");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == ST_OK || o_status == ST_COIN || o_status == ST_SHORT))
        else $error("Result carries an undefined status.");

    a_error_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_COIN || o_status == ST_SHORT) |-> o_owner == '0
            && (o_status != ST_COIN || o_stake_value == '0))
        else $error("Error result carries an owner or a value.");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall && !o_out_valid)
        else $error("Block not quiet after reset.");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("Input not stalled after a transfer was accepted.");

endmodule

bind stake_weighted_owner_table swot_checker u_swot_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_owner       (o_owner),
    .o_stake_value (o_stake_value),
    .o_status      (o_status)
);
